// ===== src/npra_pkg.sv =====
// Package for the next-fit page range allocator.
// Request/result structs, status codes and controller states. No dependencies.
package npra_pkg;

    localparam int ADDR_W = 48;
    localparam int HINT_W = 13;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_ZERO_LEN    = 3'd1;
    localparam logic [2:0] STATUS_NOT_PRIVATE = 3'd2;
    localparam logic [2:0] STATUS_BAD_FIXED   = 3'd3;
    localparam logic [2:0] STATUS_BUSY        = 3'd4;
    localparam logic [2:0] STATUS_NO_SPACE    = 3'd5;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_UNMAP = 1'b1;

    typedef struct packed {
        logic              command;
        logic              fixed_place;
        logic              private_flag;
        logic [ADDR_W-1:0] start_address;
        logic [ADDR_W-1:0] length_bytes;
    } npra_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mapped_address;
        logic [2:0]        status;
    } npra_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_DECIDE,
        S_FRD,
        S_FEV,
        S_SRD,
        S_SEV,
        S_MARK,
        S_DONE
    } npra_state_t;

endpackage

// ===== src/npra_ram.sv =====
// Page presence memory: one bit per page, synchronous read.
// Depends on nothing.
module npra_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     wdata,
    output logic                     rdata
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== src/next_fit_page_range_allocator_core.sv =====
// Next-fit page range allocator, top level: request decode, search sequencer, presence memory.
// Depends on npra_pkg and npra_ram.
//
// One request at a time; start is taken while busy is low and the result shows on
// result for one cycle with result_valid high, once S_DONE is reached. The
// receiver cannot stall: each result must be taken in the one cycle it is shown.
// Setup runs through S_CALC1, S_CALC2, S_CALC3 and S_DECIDE. A fixed map then reads
// each page of the range (S_FRD, S_FEV) and writes each (S_MARK); a search reads the
// presence memory page by page (S_SRD, S_SEV) from the hint, wrapping once, then
// writes the found run; an unmap writes one page a cycle. The presence memory is
// single-port. After reset the memory is cleared page by page with busy high.
module next_fit_page_range_allocator_core #(
    parameter int WINDOW_PAGES = 4096,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  npra_pkg::npra_req_t request,
    output logic               result_valid,
    output npra_pkg::npra_rsp_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [47:0]        cfg_data
);

    localparam int LG  = $clog2(PAGE_BYTES);
    localparam int AW  = $clog2(WINDOW_PAGES);
    localparam int IW1 = $clog2(WINDOW_PAGES + 1);
    localparam int PGW = 49 - LG;
    localparam int PW  = 48 - LG;
    localparam int HRW = 50 - LG;
    localparam int HW  = npra_pkg::HINT_W;

    npra_pkg::npra_state_t state_reg, state_next;
    npra_pkg::npra_req_t   req_reg;

    logic [47:0]    base_reg;
    logic [IW1-1:0] cur_reg, left_reg, lim_reg, start_reg, n_reg, run_reg, first_reg;
    logic [HW-1:0]  hint_reg;
    logic [PGW-1:0] pages_reg;
    logic [PW-1:0]  p0_reg, lo_reg;
    logic [48:0]    diff_reg;
    logic [HRW-1:0] hi_raw_reg, wend_reg, hi_reg;
    logic           misalign_reg, f_big_reg, fix_over_reg, pass2_reg, mark_val_reg;
    logic [47:0]    result_reg;
    logic [2:0]     status_reg;

    logic           ram_re, ram_we, ram_wdata, ram_rdata;
    logic [PW-1:0]  b0;
    logic [47:0]    wstart;
    logic [IW1-1:0] cur_inc, new_run, at_idx, room;
    logic           srd_ok, hit, unmap_go, too_big, fixed_bad;

    assign b0        = base_reg[47:LG];
    assign wstart    = {base_reg[47:LG], {LG{1'b0}}};
    assign cur_inc   = cur_reg + IW1'(1);
    assign srd_ok    = cur_inc < lim_reg;
    assign new_run   = ram_rdata ? '0 : run_reg + IW1'(1);
    assign hit       = new_run >= n_reg;
    assign at_idx    = cur_inc - n_reg;
    assign room      = IW1'(WINDOW_PAGES) - first_reg;
    assign unmap_go  = HRW'(lo_reg) < hi_reg;
    assign too_big   = pages_reg > PGW'(WINDOW_PAGES - 1);
    assign fixed_bad = (req_reg.start_address == '0) || misalign_reg;

    npra_ram #(
        .DEPTH(WINDOW_PAGES)
    ) u_ram (
        .clk  (clk),
        .rd_en(ram_re),
        .wr_en(ram_we),
        .addr (cur_reg[AW-1:0]),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            npra_pkg::S_CLEAR:
            begin
                if (cur_reg == IW1'(WINDOW_PAGES - 1))
                begin
                    state_next = npra_pkg::S_IDLE;
                end
            end
            npra_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = npra_pkg::S_CALC1;
                end
            end
            npra_pkg::S_CALC1:  state_next = npra_pkg::S_CALC2;
            npra_pkg::S_CALC2:  state_next = npra_pkg::S_CALC3;
            npra_pkg::S_CALC3:  state_next = npra_pkg::S_DECIDE;
            npra_pkg::S_DECIDE:
            begin
                priority if (req_reg.length_bytes == '0)
                    state_next = npra_pkg::S_DONE;
                else if (req_reg.command == npra_pkg::CMD_UNMAP)
                    state_next = (!misalign_reg && unmap_go) ? npra_pkg::S_MARK
                                                             : npra_pkg::S_DONE;
                else if (!req_reg.private_flag)
                    state_next = npra_pkg::S_DONE;
                else if (req_reg.fixed_place)
                    state_next = (fixed_bad || diff_reg[48] || fix_over_reg)
                                 ? npra_pkg::S_DONE : npra_pkg::S_FRD;
                else
                    state_next = too_big ? npra_pkg::S_DONE : npra_pkg::S_SRD;
            end
            npra_pkg::S_FRD:    state_next = npra_pkg::S_FEV;
            npra_pkg::S_FEV:
            begin
                priority if (ram_rdata)
                    state_next = npra_pkg::S_DONE;
                else if (left_reg == IW1'(1))
                    state_next = npra_pkg::S_MARK;
                else
                    state_next = npra_pkg::S_FRD;
            end
            npra_pkg::S_SRD:
            begin
                priority if (srd_ok)
                    state_next = npra_pkg::S_SEV;
                else if (pass2_reg)
                    state_next = npra_pkg::S_DONE;
                else
                    state_next = npra_pkg::S_SRD;
            end
            npra_pkg::S_SEV:    state_next = hit ? npra_pkg::S_MARK : npra_pkg::S_SRD;
            npra_pkg::S_MARK:
            begin
                if (left_reg == IW1'(1))
                begin
                    state_next = npra_pkg::S_DONE;
                end
            end
            npra_pkg::S_DONE:   state_next = npra_pkg::S_IDLE;
            default:            state_next = npra_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = (state_reg != npra_pkg::S_IDLE);
        result_valid = (state_reg == npra_pkg::S_DONE);
        result       = '{mapped_address: result_reg, status: status_reg};
        cfg_ready    = 1'b1;
        ram_we       = (state_reg == npra_pkg::S_CLEAR) || (state_reg == npra_pkg::S_MARK);
        ram_wdata    = (state_reg == npra_pkg::S_MARK) && mark_val_reg;
        ram_re       = (state_reg == npra_pkg::S_FRD) || ((state_reg == npra_pkg::S_SRD) && srd_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npra_pkg::S_CLEAR;
            cur_reg   <= '0;
            hint_reg  <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            unique case (state_reg)
                npra_pkg::S_CLEAR:
                begin
                    cur_reg <= cur_inc;
                end
                npra_pkg::S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= request;
                        status_reg <= npra_pkg::STATUS_OK;
                        result_reg <= '0;
                    end
                end
                npra_pkg::S_CALC1:
                begin
                    pages_reg    <= PGW'((49'(req_reg.length_bytes) + 49'(PAGE_BYTES - 1)) >> LG);
                    p0_reg       <= req_reg.start_address[47:LG];
                    misalign_reg <= (req_reg.start_address[LG-1:0] != '0);
                    diff_reg     <= 49'(req_reg.start_address) - 49'(wstart);
                end
                npra_pkg::S_CALC2:
                begin
                    hi_raw_reg <= HRW'(p0_reg) + HRW'(pages_reg);
                    wend_reg   <= HRW'(b0) + HRW'(WINDOW_PAGES);
                    lo_reg     <= (p0_reg > b0) ? p0_reg : b0;
                    f_big_reg  <= diff_reg[47:LG] > PW'(WINDOW_PAGES);
                    first_reg  <= IW1'(diff_reg[47:LG]);
                end
                npra_pkg::S_CALC3:
                begin
                    hi_reg       <= (hi_raw_reg > wend_reg) ? wend_reg : hi_raw_reg;
                    fix_over_reg <= f_big_reg || (pages_reg > PGW'(room));
                end
                npra_pkg::S_DECIDE:
                begin
                    pass2_reg <= 1'b0;
                    run_reg   <= '0;
                    priority if (req_reg.length_bytes == '0)
                        status_reg <= npra_pkg::STATUS_ZERO_LEN;
                    else if (req_reg.command == npra_pkg::CMD_UNMAP)
                    begin
                        if (misalign_reg)
                            status_reg <= npra_pkg::STATUS_BAD_FIXED;
                        cur_reg      <= IW1'(lo_reg - b0);
                        left_reg     <= IW1'(hi_reg - HRW'(lo_reg));
                        mark_val_reg <= 1'b0;
                    end
                    else if (!req_reg.private_flag)
                        status_reg <= npra_pkg::STATUS_NOT_PRIVATE;
                    else if (req_reg.fixed_place)
                    begin
                        priority if (fixed_bad)
                            status_reg <= npra_pkg::STATUS_BAD_FIXED;
                        else if (diff_reg[48] || fix_over_reg)
                            status_reg <= npra_pkg::STATUS_NO_SPACE;
                        else
                            status_reg <= npra_pkg::STATUS_OK;
                        cur_reg      <= first_reg;
                        left_reg     <= IW1'(pages_reg);
                        mark_val_reg <= 1'b1;
                    end
                    else
                    begin
                        if (too_big)
                            status_reg <= npra_pkg::STATUS_NO_SPACE;
                        if (32'(hint_reg) >= 32'(WINDOW_PAGES))
                        begin
                            cur_reg   <= '0;
                            start_reg <= '0;
                        end
                        else
                        begin
                            cur_reg   <= IW1'(hint_reg);
                            start_reg <= IW1'(hint_reg);
                        end
                        lim_reg      <= IW1'(WINDOW_PAGES);
                        n_reg        <= IW1'(pages_reg);
                        mark_val_reg <= 1'b1;
                    end
                end
                npra_pkg::S_FRD:
                begin
                end
                npra_pkg::S_FEV:
                begin
                    priority if (ram_rdata)
                        status_reg <= npra_pkg::STATUS_BUSY;
                    else if (left_reg == IW1'(1))
                    begin
                        cur_reg    <= first_reg;
                        left_reg   <= IW1'(pages_reg);
                        result_reg <= req_reg.start_address;
                    end
                    else
                    begin
                        cur_reg  <= cur_inc;
                        left_reg <= left_reg - IW1'(1);
                    end
                end
                npra_pkg::S_SRD:
                begin
                    if (!srd_ok)
                    begin
                        if (pass2_reg)
                            status_reg <= npra_pkg::STATUS_NO_SPACE;
                        pass2_reg <= 1'b1;
                        cur_reg   <= '0;
                        lim_reg   <= start_reg;
                        run_reg   <= '0;
                    end
                end
                npra_pkg::S_SEV:
                begin
                    run_reg <= new_run;
                    if (hit)
                    begin
                        cur_reg    <= at_idx;
                        left_reg   <= n_reg;
                        hint_reg   <= HW'(32'(at_idx) + 32'(n_reg));
                        result_reg <= wstart + (48'(at_idx) << LG);
                    end
                    else
                    begin
                        cur_reg <= cur_inc;
                    end
                end
                npra_pkg::S_MARK:
                begin
                    cur_reg  <= cur_inc;
                    left_reg <= left_reg - IW1'(1);
                end
                npra_pkg::S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
